// ===== rtl/upcs_pkg.sv =====
// Shared types, character codes and helpers for the URI path component splitter.
package upcs_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [3:0] HEX_TEN    = 4'ha;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_COMP = 2'd1,
		KIND_URI  = 2'd2
	} upcs_kind_t;

	// Everything one input beat produces, in compact form:
	// data bytes first, then an optional component end, then an optional URI end.
	typedef struct packed {
		logic [1:0]  dcnt;
		logic [7:0]  data0;
		logic [7:0]  data1;
		logic        close;
		logic        uri_end;
		logic [5:0]  idx;
		logic [12:0] len;
		logic [5:0]  count;
	} upcs_rec_t;

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			v = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			v = 4'(c[3:0] - 4'd1) + HEX_TEN;
		return v;
	endfunction

endpackage

// ===== rtl/upcs_front.sv =====
// Front end: tracks component state per character and builds one result record per beat.
module upcs_front #(
	parameter int COMP_LIMIT = 63,
	parameter int LEN_CAP    = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                has_char,
	input  logic [7:0]          char_in,
	input  logic                end_of_uri,
	output logic                push,
	output upcs_pkg::upcs_rec_t rec
);
	import upcs_pkg::*;

	logic        at_start_q, comp_open_q;
	logic [1:0]  pend_cnt_q;
	logic [7:0]  pend_char_q;
	logic [5:0]  comp_cnt_q;
	logic [12:0] len_q;

	logic        n_at, n_open, skip, do_close;
	logic [1:0]  n_pc;
	logic [7:0]  n_pch;
	logic [5:0]  n_cc;
	logic [12:0] n_len;
	logic [5:0]  lim;
	logic [12:0] cap;

	assign lim = 6'(COMP_LIMIT);
	assign cap = 13'(LEN_CAP);

	always_comb begin
		n_at     = at_start_q;
		n_open   = comp_open_q;
		n_pc     = pend_cnt_q;
		n_pch    = pend_char_q;
		n_cc     = comp_cnt_q;
		n_len    = len_q;
		skip     = 1'b0;
		do_close = 1'b0;
		rec      = '0;
		rec.idx  = comp_cnt_q;

		if (has_char) begin
			if (n_at) begin
				n_at = 1'b0;
				skip = (char_in == CH_SLASH);
			end
			if (!skip) begin
				if (char_in == CH_SLASH) begin
					do_close = n_open || (n_cc < lim);
				end else begin
					if (!n_open && (n_cc < lim)) begin
						n_open = 1'b1;
						n_len  = '0;
						n_pc   = 2'd0;
					end
					if (n_open) begin
						unique case (n_pc)
							2'd1: begin
								n_pch = char_in;
								n_pc  = 2'd2;
							end
							2'd2: begin
								rec.dcnt  = 2'd1;
								rec.data0 = {hex_val(n_pch), hex_val(char_in)};
								n_pc      = 2'd0;
								if (n_len < cap)
									n_len = n_len + 13'd1;
							end
							default: begin
								if (char_in == CH_PERCENT) begin
									n_pc = 2'd1;
								end else begin
									rec.dcnt  = 2'd1;
									rec.data0 = char_in;
									if (n_len < cap)
										n_len = n_len + 13'd1;
								end
							end
						endcase
					end
				end
			end
		end

		if (end_of_uri && n_open)
			do_close = 1'b1;

		if (do_close) begin
			// short escape: flush '%' and the held character literally
			if (n_pc != 2'd0) begin
				rec.dcnt  = 2'd1;
				rec.data0 = CH_PERCENT;
				if (n_len < cap)
					n_len = n_len + 13'd1;
			end
			if (n_pc == 2'd2) begin
				rec.dcnt  = 2'd2;
				rec.data1 = n_pch;
				if (n_len < cap)
					n_len = n_len + 13'd1;
			end
			rec.close = 1'b1;
			rec.len   = n_len;
			n_pc      = 2'd0;
			n_cc      = n_cc + 6'd1;
			n_open    = 1'b0;
			n_len     = '0;
		end

		if (end_of_uri) begin
			rec.uri_end = 1'b1;
			rec.count   = n_cc;
			n_at        = 1'b1;
			n_open      = 1'b0;
			n_pc        = 2'd0;
			n_pch       = '0;
			n_cc        = '0;
			n_len       = '0;
		end
	end

	assign push = accept && ((rec.dcnt != 2'd0) || rec.close || rec.uri_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			comp_open_q <= 1'b0;
			pend_cnt_q  <= 2'd0;
			pend_char_q <= '0;
			comp_cnt_q  <= '0;
			len_q       <= '0;
		end else if (accept) begin
			at_start_q  <= n_at;
			comp_open_q <= n_open;
			pend_cnt_q  <= n_pc;
			pend_char_q <= n_pch;
			comp_cnt_q  <= n_cc;
			len_q       <= n_len;
		end
	end

	a_pend_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q != 2'd0) |-> comp_open_q)
		else $error("escape pending without an open component");

endmodule

// ===== rtl/upcs_queue.sv =====
// Short record queue between the front end and the output sequencer.
module upcs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upcs_pkg::upcs_rec_t wdata,
	output logic                full,
	input  logic                pop,
	output upcs_pkg::upcs_rec_t rdata,
	output logic                empty
);
	import upcs_pkg::*;

	upcs_rec_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCOUNT_W-1:0]   count_q;

	assign full  = (count_q == QCOUNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCOUNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCOUNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

// ===== rtl/upcs_back.sv =====
// Output sequencer: walks the results of the head record, one beat per result.
module upcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  upcs_pkg::upcs_rec_t rec,
	input  logic                rec_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [7:0]          data_byte,
	output logic [5:0]          comp_index,
	output logic [12:0]         comp_length,
	output logic [5:0]          comp_count,
	output logic                last
);
	import upcs_pkg::*;

	logic [1:0] pos_q;
	logic [2:0] total;
	logic       take;
	upcs_kind_t k;

	assign total = 3'(rec.dcnt) + 3'(rec.close) + 3'(rec.uri_end);
	assign out_valid = rec_valid;
	assign last = ({1'b0, pos_q} + 3'd1) == total;
	assign take = out_valid && !out_stall;
	assign pop  = take && last;

	always_comb begin
		k           = KIND_URI;
		data_byte   = '0;
		comp_index  = '0;
		comp_length = '0;
		comp_count  = '0;
		if (pos_q < rec.dcnt) begin
			k          = KIND_DATA;
			data_byte  = (pos_q == 2'd0) ? rec.data0 : rec.data1;
			comp_index = rec.idx;
		end else if (rec.close && (pos_q == rec.dcnt)) begin
			k           = KIND_COMP;
			comp_index  = rec.idx;
			comp_length = rec.len;
		end else begin
			comp_count = rec.count;
		end
	end

	assign kind = k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (pop)
			pos_q <= '0;
		else if (take)
			pos_q <= pos_q + 2'd1;
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> ({1'b0, pos_q} < total))
		else $error("sequencer position beyond record");

	a_pos_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_valid |-> (pos_q == 2'd0))
		else $error("sequencer position nonzero with no record");

endmodule

// ===== rtl/uri_path_component_splitter.sv =====
// Top level of the URI path component splitter with percent decoding.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-------------------------------------------------
//  input    | in_valid  | in_stall  | has_char, char_in, end_of_uri
//  output   | out_valid | out_stall | kind, data_byte, comp_index, comp_length,
//           |           |           | comp_count, last
//
// One input beat per cycle while in_stall is low; the front end updates its state in the cycle the beat is taken.
// A beat producing k results (0 to 4) gives k output beats.
// A 4-record queue between front end and output sequencer; in_stall is high only when it is full.
// Output payload comes from the queue head and a registered position, so it holds under stall.
// Reset returns to the start-of-URI state with an empty queue.
module uri_path_component_splitter #(
	parameter int MAX_NAME_COMPONENTS = 64,
	parameter int MAX_COMPONENT_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        has_char,
	input  logic [7:0]  char_in,
	input  logic        end_of_uri,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [5:0]  comp_index,
	output logic [12:0] comp_length,
	output logic [5:0]  comp_count,
	output logic        last
);
	import upcs_pkg::*;

	localparam int COMP_LIMIT = (MAX_NAME_COMPONENTS - 1 > 63) ? 63 : MAX_NAME_COMPONENTS - 1;
	localparam int LEN_CAP    = (MAX_COMPONENT_BYTES > 8191) ? 8191 : MAX_COMPONENT_BYTES;

	upcs_rec_t front_rec, head_rec;
	logic      push, pop, full, empty, accept;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	upcs_front #(
		.COMP_LIMIT (COMP_LIMIT),
		.LEN_CAP    (LEN_CAP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.has_char   (has_char),
		.char_in    (char_in),
		.end_of_uri (end_of_uri),
		.push       (push),
		.rec        (front_rec)
	);

	upcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_rec),
		.full   (full),
		.pop    (pop),
		.rdata  (head_rec),
		.empty  (empty)
	);

	upcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (head_rec),
		.rec_valid   (!empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.comp_index  (comp_index),
		.comp_length (comp_length),
		.comp_count  (comp_count),
		.last        (last)
	);

endmodule

// ===== tb/uri_path_component_splitter_test.sv =====
// Self-checking testbench for the URI path component splitter: directed and random paths.
module uri_path_component_splitter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import upcs_pkg::*;

	localparam int NAME_COMPONENTS = 64;
	localparam int COMPONENT_BYTES = 4096;
	localparam int COMP_LIMIT = (NAME_COMPONENTS - 1 > 63) ? 63 : NAME_COMPONENTS - 1;
	localparam int LEN_LIMIT = (COMPONENT_BYTES > 8191) ? 8191 : COMPONENT_BYTES;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		upcs_kind_t  kind;
		logic [7:0]  data_byte;
		logic [5:0]  comp_index;
		logic [12:0] comp_length;
		logic [5:0]  comp_count;
		logic        last;
	} path_token_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        has_char = 1'b0;
	logic [7:0]  char_in = 8'h00;
	logic        end_of_uri = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [5:0]  comp_index;
	logic [12:0] comp_length;
	logic [5:0]  comp_count;
	logic        last;

	// splitter state as predicted
	bit       uri_fresh = 1'b1;
	bit       comp_active = 1'b0;
	bit [1:0] esc_held = 2'd0;	// 0 none, 1 '%', 2 '%' plus one char
	bit [7:0] esc_first = 8'h00;
	int       comps_seen = 0;
	int       decoded_len = 0;

	path_token_t tokens_due[$];
	path_token_t step_tokens[$];

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit want_hold = 1'b0;
	bit holding = 1'b0;
	int mismatches = 0;
	int tokens_checked = 0;
	int beats_sent = 0;
	int uris_sent = 0;
	int stalled_input_cycles = 0;

	uri_path_component_splitter #(
		.MAX_NAME_COMPONENTS(NAME_COMPONENTS),
		.MAX_COMPONENT_BYTES(COMPONENT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.has_char(has_char),
		.char_in(char_in),
		.end_of_uri(end_of_uri),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.comp_index(comp_index),
		.comp_length(comp_length),
		.comp_count(comp_count),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [3:0] nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 10);
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 10);
		return 4'd0;
	endfunction

	function automatic void add_token(upcs_kind_t k, logic [7:0] b, int idx, int len, int cnt);
		path_token_t t;
		t.kind = k;
		t.data_byte = b;
		t.comp_index = 6'(idx);
		t.comp_length = 13'(len);
		t.comp_count = 6'(cnt);
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		add_token(KIND_DATA, b, comps_seen, 0, 0);
		if (decoded_len < LEN_LIMIT)
			decoded_len++;
	endfunction

	function automatic void close_component();
		// an unfinished escape goes out literally
		if (esc_held != 2'd0)
			add_byte(CH_PERCENT);
		if (esc_held == 2'd2)
			add_byte(esc_first);
		esc_held = 2'd0;
		add_token(KIND_COMP, 8'h00, comps_seen, decoded_len, 0);
		comps_seen++;
		comp_active = 1'b0;
		decoded_len = 0;
	endfunction

	function automatic void split_path_beat(logic h, logic [7:0] c, logic e);
		bit skip;
		skip = 1'b0;
		step_tokens.delete();
		if (h) begin
			if (uri_fresh) begin
				uri_fresh = 1'b0;
				skip = (c == CH_SLASH);
			end
			if (!skip) begin
				if (c == CH_SLASH) begin
					if (comp_active || comps_seen < COMP_LIMIT)
						close_component();
				end else begin
					if (!comp_active && comps_seen < COMP_LIMIT) begin
						comp_active = 1'b1;
						decoded_len = 0;
						esc_held = 2'd0;
					end
					if (comp_active) begin
						if (esc_held == 2'd1) begin
							esc_first = c;
							esc_held = 2'd2;
						end else if (esc_held == 2'd2) begin
							add_byte({nibble(esc_first), nibble(c)});
							esc_held = 2'd0;
						end else if (c == CH_PERCENT) begin
							esc_held = 2'd1;
						end else begin
							add_byte(c);
						end
					end
				end
			end
		end
		if (e) begin
			if (comp_active)
				close_component();
			add_token(KIND_URI, 8'h00, 0, 0, comps_seen);
			uri_fresh = 1'b1;
			comp_active = 1'b0;
			esc_held = 2'd0;
			esc_first = 8'h00;
			comps_seen = 0;
			decoded_len = 0;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
	endfunction

	function automatic void report_failure(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endfunction

	function automatic string token_text(logic [1:0] k, logic [7:0] b, logic [5:0] idx,
			logic [12:0] len, logic [5:0] cnt, logic lst);
		return $sformatf("kind=%0d data=%02h idx=%0d len=%0d cnt=%0d last=%0b",
			k, b, idx, len, cnt, lst);
	endfunction

	function automatic void check_token();
		path_token_t want;
		if (tokens_due.size() == 0) begin
			report_failure({"unexpected result ",
				token_text(kind, data_byte, comp_index, comp_length, comp_count, last)});
			return;
		end
		want = tokens_due.pop_front();
		tokens_checked++;
		if (kind !== want.kind || data_byte !== want.data_byte || comp_index !== want.comp_index ||
				comp_length !== want.comp_length || comp_count !== want.comp_count ||
				last !== want.last)
			report_failure($sformatf("result %0d: expected %s, got %s", tokens_checked,
				token_text(want.kind, want.data_byte, want.comp_index, want.comp_length,
					want.comp_count, want.last),
				token_text(kind, data_byte, comp_index, comp_length, comp_count, last)));
	endfunction

	// long receiver hold-off, counted here in cycles
	initial begin : receiver_hold
		forever begin
			@(posedge clk);
			if (want_hold) begin
				want_hold = 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end
		end
	end

	// output side: checks each accepted beat and plays the stall pattern
	initial begin : result_drain
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				check_token();
			if (in_valid && in_stall)
				stalled_input_cycles++;
			if (holding) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 18);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// valid stays up from one beat to the next unless a gap is inserted
	task automatic send_beat(input logic h, input logic [7:0] c, input logic e);
		int gap;
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		has_char <= h;
		char_in <= c;
		end_of_uri <= e;
		do @(posedge clk); while (in_stall);
		split_path_beat(h, c, e);
		beats_sent++;
	endtask

	// split_end puts end_of_uri on a separate beat with no character
	task automatic send_text(input logic [7:0] txt[$], input bit noisy, input bit split_end);
		foreach (txt[i]) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_beat(1'b0, 8'($urandom), 1'b0);
			send_beat(1'b1, txt[i], !split_end && i == txt.size() - 1);
		end
		if (split_end || txt.size() == 0)
			send_beat(1'b0, 8'($urandom), 1'b1);
		uris_sent++;
	endtask

	function automatic logic [7:0] any_hex_digit();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 8'("0" + v);
		if (v < 16)
			return 8'("a" + v - 10);
		return 8'("A" + v - 16);
	endfunction

	task automatic random_uri(input int max_comps, input int max_len, input bit noisy);
		logic [7:0] txt[$];
		int ncomp;
		int clen;
		int pick;
		ncomp = $urandom_range(0, max_comps);
		if ($urandom_range(0, 1))
			txt.push_back(CH_SLASH);
		for (int k = 0; k < ncomp; k++) begin
			if (k > 0)
				txt.push_back(CH_SLASH);
			clen = $urandom_range(0, max_len);
			for (int j = 0; j < clen; j++) begin
				pick = $urandom_range(0, 19);
				if (pick < 10) begin
					txt.push_back(8'($urandom_range(8'h61, 8'h7a)));
				end else if (pick < 14) begin
					txt.push_back(CH_PERCENT);
					txt.push_back(any_hex_digit());
					txt.push_back(any_hex_digit());
				end else if (pick < 16) begin
					txt.push_back(CH_PERCENT);
				end else begin
					txt.push_back(8'($urandom));
				end
			end
		end
		if ($urandom_range(0, 3) == 0)
			txt.push_back(CH_SLASH);
		send_text(txt, noisy, $urandom_range(0, 3) == 0);
	endtask

	task automatic test_directed();
		logic [7:0] txt[$];
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		txt = {};
		send_text(txt, 1'b0, 1'b1);
		// leading slash, zero byte, both hex cases, non-hex digit, empty component,
		// short escape holding one char when the path ends
		txt = {CH_SLASH, 8'h00, CH_PERCENT, 8'("4"), 8'("a"), CH_PERCENT, 8'("F"), 8'("G"),
			CH_SLASH, CH_SLASH, 8'hff, CH_PERCENT, 8'("z")};
		send_text(txt, 1'b0, 1'b0);
		// lone percent closed by a slash, trailing slash on the end beat
		txt = {8'("a"), CH_PERCENT, CH_SLASH, 8'("b"), CH_SLASH};
		send_text(txt, 1'b0, 1'b0);
		// slashes only, followed by an empty beat and an empty end beat
		send_beat(1'b1, CH_SLASH, 1'b0);
		send_beat(1'b1, CH_SLASH, 1'b0);
		send_beat(1'b0, 8'h5a, 1'b0);
		send_beat(1'b0, 8'ha5, 1'b1);
		uris_sent++;
	endtask

	task automatic test_random_paths(input int beat_budget, input bit with_idling);
		int stop_at;
		stop_at = beats_sent + beat_budget;
		while (beats_sent < stop_at) begin
			tx_idle = with_idling && $urandom_range(0, 3) != 0;
			rx_idle = with_idling && $urandom_range(0, 3) != 0;
			random_uri(5, 6, 1'b1);
		end
	endtask

	task automatic test_component_limit();
		logic [7:0] txt[$];
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		txt = {};
		repeat (COMP_LIMIT + 3) begin
			if ($urandom_range(0, 7) == 0)
				txt.push_back(8'($urandom_range(8'h61, 8'h7a)));
			txt.push_back(CH_SLASH);
		end
		// past the limit all text is dropped
		txt.push_back(8'("q"));
		txt.push_back(CH_PERCENT);
		txt.push_back(8'("4"));
		send_text(txt, 1'b1, 1'b0);
	endtask

	task automatic test_output_hold();
		logic [7:0] txt[$];
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		want_hold = 1'b1;
		txt = {};
		repeat (40)
			txt.push_back(($urandom_range(0, 4) == 0) ? CH_SLASH : 8'($urandom_range(8'h30, 8'h7e)));
		send_text(txt, 1'b0, 1'b0);
	endtask

	task automatic test_long_component();
		logic [7:0] txt[$];
		logic [7:0] c;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		txt = {};
		repeat (24) begin
			c = 8'($urandom);
			if (c == CH_SLASH || c == CH_PERCENT)
				c = 8'("x");
			txt.push_back(c);
		end
		txt.push_back(CH_SLASH);
		txt.push_back(8'("o"));
		txt.push_back(8'("k"));
		send_text(txt, 1'b0, 1'b1);
	endtask

	initial begin : run
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_paths(45, 1'b1);
		test_component_limit();
		test_output_hold();
		test_long_component();
		test_random_paths(20, 1'b0);
		in_valid <= 1'b0;
		while (tokens_due.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Ran %0d paths in %0d input beats and compared %0d results.",
			uris_sent, beats_sent, tokens_checked);
		$display("Covered escapes, empty components, the component limit and a long hold-off; %s",
			$sformatf("input held off for %0d cycles.", stalled_input_cycles));
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
